FILE: hw/rtl/cpfw_pkg.sv
// cell pixel format writer: shared constants and codes
// no dependencies; used by cell_pixel_format_writer
`default_nettype none

package cpfw_pkg;

   // field widths
   localparam int ORIGIN_W = 12;
   localparam int PIXEL_W  = 32;
   localparam int OFFSET_W = 26;
   localparam int SIZE_W   = 2;
   localparam int FMT_W    = 2;
   localparam int STRIDE_W = 15;
   localparam int SCREEN_W = 13;
   localparam int CELL_W   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_HEIGHT   = 3'd5;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_GRAY   = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd2;
   localparam logic [FMT_W-1:0] FMT_RGB32  = 2'd3;

   // write sizes
   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

   // gray weights
   localparam logic [7:0] GRAY_R = 8'd77;
   localparam logic [7:0] GRAY_G = 8'd150;
   localparam logic [7:0] GRAY_B = 8'd29;

   // reset values
   localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT  = FMT_RGB32;
   localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE   = 15'd4096;
   localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
   localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
   localparam logic [CELL_W-1:0]   RST_CELL_WIDTH    = 7'd8;
   localparam logic [CELL_W-1:0]   RST_CELL_HEIGHT   = 7'd16;

endpackage

`default_nettype wire

FILE: hw/rtl/cell_pixel_format_writer.sv
// cell pixel format writer: top level, position tracking, clipping and conversion
// depends on cpfw_pkg
`default_nettype none

// Takes the pixels of one character cell in raster order and gives a framebuffer
// byte offset, converted data and write size for each visible pixel. Clipped pixels
// give no word. One input word is accepted every cycle while the result side keeps up.
// A held result stalls the input once the input register is also full. The input
// register takes each pixel word, holding its screen position, and the result register
// its write word. One stage holds the line-stride multiply and the format mux, and it
// feeds the result register. The framebuffer base is added outside the block.
module cell_pixel_format_writer #(
   parameter int MAX_CELL_DIM   = 64,
   parameter int MAX_SCREEN_DIM = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_write,
   input  wire logic [cpfw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cpfw_pkg::CSR_DATA_W-1:0]   csr_data,
   // input pixels
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_first_of_cell,
   input  wire logic [cpfw_pkg::ORIGIN_W-1:0]     req_origin_x,
   input  wire logic [cpfw_pkg::ORIGIN_W-1:0]     req_origin_y,
   input  wire logic [cpfw_pkg::PIXEL_W-1:0]      req_background,
   input  wire logic [cpfw_pkg::PIXEL_W-1:0]      req_source_pixel,
   // framebuffer writes
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cpfw_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   output logic [cpfw_pkg::PIXEL_W-1:0]           rsp_write_data,
   output logic [cpfw_pkg::SIZE_W-1:0]            rsp_write_size
);

   localparam int POS_W  = (MAX_CELL_DIM > 1) ? $clog2(MAX_CELL_DIM) : 1;
   localparam int CDIM_W = $clog2(MAX_CELL_DIM + 1);
   localparam int AX_W   = cpfw_pkg::ORIGIN_W + 1;
   localparam int PROD_W = AX_W + cpfw_pkg::STRIDE_W;

   // configuration registers
   logic [cpfw_pkg::FMT_W-1:0]    pixel_format_ff;
   logic [cpfw_pkg::STRIDE_W-1:0] line_stride_ff;
   logic [cpfw_pkg::SCREEN_W-1:0] screen_width_ff;
   logic [cpfw_pkg::SCREEN_W-1:0] screen_height_ff;
   logic [cpfw_pkg::CELL_W-1:0]   cell_width_ff;
   logic [cpfw_pkg::CELL_W-1:0]   cell_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff  <= cpfw_pkg::RST_PIXEL_FORMAT;
         line_stride_ff   <= cpfw_pkg::RST_LINE_STRIDE;
         screen_width_ff  <= cpfw_pkg::RST_SCREEN_WIDTH;
         screen_height_ff <= cpfw_pkg::RST_SCREEN_HEIGHT;
         cell_width_ff    <= cpfw_pkg::RST_CELL_WIDTH;
         cell_height_ff   <= cpfw_pkg::RST_CELL_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            cpfw_pkg::CSR_PIXEL_FORMAT: begin
               pixel_format_ff <= csr_data[cpfw_pkg::FMT_W-1:0];
            end
            cpfw_pkg::CSR_LINE_STRIDE: begin
               line_stride_ff <= csr_data[cpfw_pkg::STRIDE_W-1:0];
            end
            cpfw_pkg::CSR_SCREEN_WIDTH: begin
               screen_width_ff <= csr_data[cpfw_pkg::SCREEN_W-1:0];
            end
            cpfw_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_data[cpfw_pkg::SCREEN_W-1:0];
            end
            cpfw_pkg::CSR_CELL_WIDTH: begin
               cell_width_ff <= csr_data[cpfw_pkg::CELL_W-1:0];
            end
            cpfw_pkg::CSR_CELL_HEIGHT: begin
               cell_height_ff <= csr_data[cpfw_pkg::CELL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective cell size
   logic [CDIM_W-1:0] cell_w_eff;
   logic [CDIM_W-1:0] cell_h_eff;

   always_comb begin
      if (cell_width_ff == '0) begin
         cell_w_eff = CDIM_W'(1);
      end else if (32'(cell_width_ff) > MAX_CELL_DIM) begin
         cell_w_eff = CDIM_W'(MAX_CELL_DIM);
      end else begin
         cell_w_eff = CDIM_W'(cell_width_ff);
      end
      if (cell_height_ff == '0) begin
         cell_h_eff = CDIM_W'(1);
      end else if (32'(cell_height_ff) > MAX_CELL_DIM) begin
         cell_h_eff = CDIM_W'(MAX_CELL_DIM);
      end else begin
         cell_h_eff = CDIM_W'(cell_height_ff);
      end
   end

   // pipeline control
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic req_take;
   logic s1_visible;
   logic s1_move;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && (!s1_visible || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   // position inside the cell
   logic [POS_W-1:0] column_ff;
   logic [POS_W-1:0] column_in;
   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] row_in;
   logic [POS_W-1:0] column_cur;
   logic [POS_W-1:0] row_cur;

   always_comb begin
      column_cur = req_first_of_cell ? '0 : column_ff;
      row_cur    = req_first_of_cell ? '0 : row_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      if (req_take) begin
         if (32'(column_cur) + 1 >= 32'(cell_w_eff)) begin
            column_in = '0;
            if (32'(row_cur) + 1 >= 32'(cell_h_eff)) begin
               row_in = '0;
            end else begin
               row_in = row_cur + POS_W'(1);
            end
         end else begin
            column_in = column_cur + POS_W'(1);
            row_in    = row_cur;
         end
      end
   end

   // input register
   logic [AX_W-1:0]              s1_ax_ff;
   logic [AX_W-1:0]              s1_ay_ff;
   logic [cpfw_pkg::PIXEL_W-1:0] s1_bg_ff;
   logic [cpfw_pkg::PIXEL_W-1:0] s1_src_ff;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ax_ff  <= AX_W'(req_origin_x) + AX_W'(column_cur);
         s1_ay_ff  <= AX_W'(req_origin_y) + AX_W'(row_cur);
         s1_bg_ff  <= req_background;
         s1_src_ff <= req_source_pixel;
      end
   end

   // clip, offset and conversion
   logic [7:0]                    red;
   logic [7:0]                    green;
   logic [7:0]                    blue;
   logic [15:0]                   gray_sum;
   logic                          transparent;
   logic [PROD_W-1:0]             line_prod;
   logic [cpfw_pkg::OFFSET_W-1:0] col_bytes;
   logic [cpfw_pkg::OFFSET_W-1:0] offset_in;
   logic [cpfw_pkg::PIXEL_W-1:0]  data_in;
   logic [cpfw_pkg::SIZE_W-1:0]   size_in;

   assign s1_visible = (32'(s1_ax_ff) < 32'(screen_width_ff))
                    && (32'(s1_ax_ff) < MAX_SCREEN_DIM)
                    && (32'(s1_ay_ff) < 32'(screen_height_ff))
                    && (32'(s1_ay_ff) < MAX_SCREEN_DIM);

   assign red         = s1_src_ff[23:16];
   assign green       = s1_src_ff[15:8];
   assign blue        = s1_src_ff[7:0];
   assign transparent = (s1_src_ff == '0);
   assign gray_sum    = (16'(red) * 16'(cpfw_pkg::GRAY_R))
                      + (16'(green) * 16'(cpfw_pkg::GRAY_G))
                      + (16'(blue) * 16'(cpfw_pkg::GRAY_B));
   assign line_prod   = PROD_W'(s1_ay_ff) * PROD_W'(line_stride_ff);

   always_comb begin
      case (pixel_format_ff)
         cpfw_pkg::FMT_GRAY: begin
            size_in   = cpfw_pkg::SIZE_BYTE;
            col_bytes = cpfw_pkg::OFFSET_W'(s1_ax_ff);
            data_in   = transparent ? 32'(s1_bg_ff[7:0]) : 32'(gray_sum[15:8]);
         end
         cpfw_pkg::FMT_RGB555: begin
            size_in   = cpfw_pkg::SIZE_HALF;
            col_bytes = cpfw_pkg::OFFSET_W'({s1_ax_ff, 1'b0});
            data_in   = transparent ? 32'(s1_bg_ff[15:0])
                                    : 32'({1'b0, red[7:3], green[7:3], blue[7:3]});
         end
         cpfw_pkg::FMT_RGB565: begin
            size_in   = cpfw_pkg::SIZE_HALF;
            col_bytes = cpfw_pkg::OFFSET_W'({s1_ax_ff, 1'b0});
            data_in   = transparent ? 32'(s1_bg_ff[15:0])
                                    : 32'({red[7:3], green[7:2], blue[7:3]});
         end
         default: begin
            size_in   = cpfw_pkg::SIZE_WORD;
            col_bytes = cpfw_pkg::OFFSET_W'({s1_ax_ff, 2'b00});
            data_in   = transparent ? s1_bg_ff : 32'({red, green, blue});
         end
      endcase
      offset_in = cpfw_pkg::OFFSET_W'(line_prod) + col_bytes;
   end

   // result register
   logic [cpfw_pkg::OFFSET_W-1:0] offset_ff;
   logic [cpfw_pkg::PIXEL_W-1:0]  data_ff;
   logic [cpfw_pkg::SIZE_W-1:0]   size_ff;

   assign rsp_valid_in = (s1_move && s1_visible) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (s1_move && s1_visible) begin
         offset_ff <= offset_in;
         data_ff   <= data_in;
         size_ff   <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_write_data  = data_ff;
   assign rsp_write_size  = size_ff;

endmodule

`default_nettype wire
